// ----- src/bli_pkg.sv -----
// Shared types and constants for the bounded list core.
// Used by the top level; no dependencies.
package bli_pkg;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 8;
	localparam int OP_W    = 2;

	// Command codes carried on the input tuser.
	typedef enum logic [OP_W-1:0] {
		OP_FRONT  = 2'd0,
		OP_BACK   = 2'd1,
		OP_DELETE = 2'd2,
		OP_KEEP   = 2'd3
	} op_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_DUMP_RD,
		ST_DUMP_OUT
	} state_t;

endpackage

// ----- src/bli_addr_unit.sv -----
// Circular address unit: base plus offset, wrapped at the list capacity.
// Shared by every access of the sequencer; no dependencies.
module bli_addr_unit #(
	parameter int CAPACITY = 32,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  logic [AW-1:0] base,
	input  logic [AW-1:0] offset,
	output logic [AW-1:0] addr
);

	localparam logic [AW:0] CAP_EXT = (AW+1)'(CAPACITY);

	logic [AW:0] sum;
	logic [AW:0] wrapped;

	// Add, then fold back once; both operands stay below the capacity.
	always_comb begin
		sum = {1'b0, base} + {1'b0, offset};
		if (sum >= CAP_EXT) begin
			wrapped = sum - CAP_EXT;
		end else begin
			wrapped = sum;
		end
		addr = wrapped[AW-1:0];
	end

endmodule

// ----- src/bounded_list_insert_delete_core.sv -----
// Bounded ordered list core: insert front/back, delete by index, dump per command.
// Depends on bli_pkg and bli_addr_unit.
//
// The list lives in a circular buffer of CAPACITY entries addressed from a head
// pointer, so front and back inserts and a delete of the front entry move no
// entries; they only write the new entry or move the head. A delete further in
// shifts the tail down one entry at a time through the single memory port pair,
// reading each moved entry and writing it one slot lower, then closes the list.
// The dump then reads each entry and presents it, holding each beat until the
// sink takes it; it covers the list as it stands after the command, and sends a
// single beat for an empty list.
// The input is not ready until the last beat of the dump has been taken.
// Entries are not cleared at reset; only entries below the count are read.
module bounded_list_insert_delete_core
	import bli_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value [31:0], position [39:32]
	input  logic [1:0]  s_tuser,   // op [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // element [31:0]
	output logic        m_tlast,
	output logic [1:0]  m_tuser    // empty_res [0], dropped [1]
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
	localparam logic [AW-1:0] CAP_M1  = AW'(CAPACITY - 1);

	// Storage and registered read.
	logic [VALUE_W-1:0] mem [CAPACITY];
	logic [VALUE_W-1:0] rd_q;

	state_t state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] idx_p1;
	logic last_q, last_d;
	logic empty_q, empty_d;
	logic drop_q, drop_d;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;

	logic [AW-1:0] unit_off;
	logic [AW-1:0] unit_addr;

	op_t              in_op;
	logic [VALUE_W-1:0] in_value;
	logic [POS_W-1:0]   in_pos;
	logic               full;

	assign in_op    = op_t'(s_tuser);
	assign in_value = s_tdata[VALUE_W-1:0];
	assign in_pos   = s_tdata[VALUE_W +: POS_W];
	assign full     = (count_q == CAP_CNT);
	assign idx_p1   = idx_q + CW'(1);

	bli_addr_unit #(
		.CAPACITY(CAPACITY),
		.AW      (AW)
	) u_addr (
		.base  (head_q),
		.offset(unit_off),
		.addr  (unit_addr)
	);

	// Sequencer: next state, address unit operand and memory controls.
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		idx_d     = idx_q;
		last_d    = last_q;
		empty_d   = empty_q;
		drop_d    = drop_q;
		mem_we    = 1'b0;
		mem_waddr = unit_addr;
		mem_wdata = in_value;
		mem_re    = 1'b0;
		mem_raddr = unit_addr;
		unit_off  = idx_q[AW-1:0];
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				case (in_op)
					OP_FRONT: unit_off = CAP_M1;
					OP_BACK:  unit_off = count_q[AW-1:0];
					OP_DELETE: unit_off = AW'(1);
					default:  unit_off = '0;
				endcase
				if (s_tvalid) begin
					idx_d   = '0;
					drop_d  = 1'b0;
					state_d = ST_DUMP_RD;
					case (in_op)
						OP_FRONT: begin
							if (full) begin
								drop_d = 1'b1;
							end else begin
								mem_we  = 1'b1;
								head_d  = unit_addr;
								count_d = count_q + CW'(1);
							end
						end
						OP_BACK: begin
							if (full) begin
								drop_d = 1'b1;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						OP_DELETE: begin
							if (in_pos < POS_W'(count_q)) begin
								if (in_pos == '0) begin
									head_d  = unit_addr;
									count_d = count_q - CW'(1);
								end else begin
									idx_d   = CW'(in_pos);
									state_d = ST_SHIFT_RD;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SHIFT_RD: begin
				// Fetch the entry above the hole, or close the list.
				unit_off = idx_p1[AW-1:0];
				if (idx_p1 >= count_q) begin
					count_d = count_q - CW'(1);
					idx_d   = '0;
					state_d = ST_DUMP_RD;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_SHIFT_WR;
				end
			end
			ST_SHIFT_WR: begin
				// Move it down one slot.
				unit_off  = idx_q[AW-1:0];
				mem_we    = 1'b1;
				mem_wdata = rd_q;
				idx_d     = idx_p1;
				state_d   = ST_SHIFT_RD;
			end
			ST_DUMP_RD: begin
				unit_off = idx_q[AW-1:0];
				empty_d  = (count_q == '0);
				last_d   = (count_q == '0) || (idx_p1 == count_q);
				mem_re   = (count_q != '0);
				state_d  = ST_DUMP_OUT;
			end
			ST_DUMP_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (last_q) begin
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_p1;
						state_d = ST_DUMP_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			idx_q   <= idx_d;
		end
	end

	// Beat flags travel with the payload.
	always_ff @(posedge clk) begin
		last_q  <= last_d;
		empty_q <= empty_d;
		drop_q  <= drop_d;
	end

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// Output beat.
	assign m_tdata = empty_q ? '0 : rd_q;
	assign m_tlast = last_q;
	assign m_tuser = {drop_q, empty_q};

	// Checks.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("list count above capacity");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a beat is pending");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && empty_q) |-> (m_tlast && count_q == '0))
		else $error("empty beat not alone or list not empty");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("not idle after final beat");

	a_accept_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("accepted command produced no dump");

endmodule
